[design/lstk_pkg.sv]
// Shared types and constants for the record stack with key search.
// No dependencies; used by lstk_ctrl and lifo_stack_with_key_search.
package lstk_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int KEY_W       = 37;
    localparam int VAL_W       = 64;
    localparam int TAG_W       = 8;
    localparam int COUNT_NOW_W = 7;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_SRCH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_POP  = 2'd1,
        S_SRCH = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_IN   = 2'd1,
        SRC_RAM  = 2'd2
    } t_rsrc;

    typedef struct packed {
        t_cmd                     command;
        logic [KEY_W-1:0]         entry_key;
        logic [KEY_W-1:0]         entry_second_key;
        logic signed [VAL_W-1:0]  entry_value;
        logic [TAG_W-1:0]         entry_tag;
    } t_in_beat;

    typedef struct packed {
        t_status                  status;
        logic [KEY_W-1:0]         rec_key;
        logic [KEY_W-1:0]         rec_second_key;
        logic signed [VAL_W-1:0]  rec_value;
        logic [TAG_W-1:0]         rec_tag;
        logic [COUNT_NOW_W-1:0]   count_now;
    } t_out_beat;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [KEY_W-1:0]         second_key;
        logic signed [VAL_W-1:0]  value;
        logic [TAG_W-1:0]         tag;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_ram_req;

    typedef struct packed {
        logic             fire;
        t_status          status;
        t_rsrc            src;
        logic [CNT_W-1:0] count;
    } t_res_ctl;

endpackage

[design/lstk_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lstk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/lstk_ctrl.sv]
// Command sequencer: record count, RAM access and top-down key scan.
// Depends on lstk_pkg.
module lstk_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  lstk_pkg::t_cmd           i_cmd,
    input  logic [lstk_pkg::KEY_W-1:0] i_key,
    input  logic [lstk_pkg::KEY_W-1:0] i_rd_key,
    output logic                     o_busy,
    output lstk_pkg::t_ram_req       o_ram,
    output lstk_pkg::t_res_ctl       o_res
);

    lstk_pkg::t_state                  r_state, n_state;
    logic [lstk_pkg::CNT_W-1:0]        r_count, n_count;
    logic [lstk_pkg::ADDR_W-1:0]       r_addr,  n_addr;
    logic [lstk_pkg::KEY_W-1:0]        r_want,  n_want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lstk_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_addr <= n_addr;
        r_want <= n_want;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_want       = r_want;
        o_ram        = '0;
        o_res.fire   = 1'b0;
        o_res.status = lstk_pkg::ST_OK;
        o_res.src    = lstk_pkg::SRC_NONE;
        unique case (r_state)
            lstk_pkg::S_IDLE: begin
                if (i_start) begin
                    o_res.fire = 1'b1;
                    case (i_cmd)
                        lstk_pkg::CMD_PUSH: begin
                            if (r_count == lstk_pkg::CNT_W'(lstk_pkg::STACK_DEPTH)) begin
                                o_res.status = lstk_pkg::ST_FULL;
                            end else begin
                                o_ram.we  = 1'b1;
                                o_ram.addr = r_count[lstk_pkg::ADDR_W-1:0];
                                o_res.src = lstk_pkg::SRC_IN;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        lstk_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                o_res.status = lstk_pkg::ST_EMPTY;
                            end else begin
                                o_res.fire = 1'b0;
                                n_count    = r_count - 1'b1;
                                o_ram.re   = 1'b1;
                                o_ram.addr = n_count[lstk_pkg::ADDR_W-1:0];
                                n_state    = lstk_pkg::S_POP;
                            end
                        end
                        lstk_pkg::CMD_SRCH: begin
                            if (r_count == '0) begin
                                o_res.status = lstk_pkg::ST_EMPTY;
                            end else begin
                                o_res.fire = 1'b0;
                                n_addr     = lstk_pkg::ADDR_W'(r_count - 1'b1);
                                n_want     = i_key;
                                o_ram.re   = 1'b1;
                                o_ram.addr = n_addr;
                                n_state    = lstk_pkg::S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lstk_pkg::S_POP: begin
                o_res.fire = 1'b1;
                o_res.src  = lstk_pkg::SRC_RAM;
                n_state    = lstk_pkg::S_IDLE;
            end
            lstk_pkg::S_SRCH: begin
                // read data belongs to r_addr; on a miss above entry 0 the next lower entry is fetched meanwhile
                if (i_rd_key == r_want) begin
                    o_res.fire = 1'b1;
                    o_res.src  = lstk_pkg::SRC_RAM;
                    n_state    = lstk_pkg::S_IDLE;
                end else if (r_addr == '0) begin
                    o_res.fire   = 1'b1;
                    o_res.status = lstk_pkg::ST_NOT_FOUND;
                    n_state      = lstk_pkg::S_IDLE;
                end else begin
                    n_addr     = r_addr - 1'b1;
                    o_ram.re   = 1'b1;
                    o_ram.addr = n_addr;
                end
            end
            default: begin
                n_state = lstk_pkg::S_IDLE;
            end
        endcase
        o_res.count = n_count;
    end

    assign o_busy = (r_state != lstk_pkg::S_IDLE);

endmodule

[design/lifo_stack_with_key_search.sv]
// Bounded LIFO record stack with top-down key search; top level.
// Depends on lstk_pkg, lstk_ram and lstk_ctrl.
//
// A command beat is taken when start is high and busy is low. Push, and pop
// or search on an empty stack, and the unused command code complete in the
// idle state; pop completes in the pop state after its RAM read, and search
// keeps busy high while it scans, since the record RAM has one port and the
// scan reads one entry per cycle from the top down. Each beat gives one result,
// presented on o_result for exactly one cycle with o_valid, in the cycle after
// the command completes; the receiver cannot stall, and a new command may be
// taken in the cycle the previous result is shown. Reset needs no clearing pass:
// only entries below the count are ever read.
module lifo_stack_with_key_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  lstk_pkg::t_in_beat   i_item,
    output logic                 busy,
    output logic                 o_valid,
    output lstk_pkg::t_out_beat  o_result
);

    lstk_pkg::t_ram_req   ram_req;
    lstk_pkg::t_res_ctl   res_ctl;
    lstk_pkg::t_rec       wr_rec;
    lstk_pkg::t_rec       rd_rec;
    lstk_pkg::t_out_beat  n_result;
    lstk_pkg::t_out_beat  r_result;
    logic                 r_valid;

    assign wr_rec.key        = i_item.entry_key;
    assign wr_rec.second_key = i_item.entry_second_key;
    assign wr_rec.value      = i_item.entry_value;
    assign wr_rec.tag        = i_item.entry_tag;

    lstk_ram #(
        .WIDTH (lstk_pkg::REC_W),
        .DEPTH (lstk_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_re    (ram_req.re),
        .i_addr  (ram_req.addr),
        .i_wdata (wr_rec),
        .o_rdata (rd_rec)
    );

    lstk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_item.command),
        .i_key    (i_item.entry_key),
        .i_rd_key (rd_rec.key),
        .o_busy   (busy),
        .o_ram    (ram_req),
        .o_res    (res_ctl)
    );

    always_comb begin
        n_result.status    = res_ctl.status;
        n_result.count_now = lstk_pkg::COUNT_NOW_W'(res_ctl.count);
        case (res_ctl.src)
            lstk_pkg::SRC_IN: begin
                n_result.rec_key        = i_item.entry_key;
                n_result.rec_second_key = i_item.entry_second_key;
                n_result.rec_value      = i_item.entry_value;
                n_result.rec_tag        = i_item.entry_tag;
            end
            lstk_pkg::SRC_RAM: begin
                n_result.rec_key        = rd_rec.key;
                n_result.rec_second_key = rd_rec.second_key;
                n_result.rec_value      = rd_rec.value;
                n_result.rec_tag        = rd_rec.tag;
            end
            default: begin
                n_result.rec_key        = '0;
                n_result.rec_second_key = '0;
                n_result.rec_value      = '0;
                n_result.rec_tag        = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res_ctl.fire;
        end
        if (res_ctl.fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command == lstk_pkg::CMD_PUSH
         && res_ctl.status == lstk_pkg::ST_OK)
        |=> (o_valid && o_result.status == lstk_pkg::ST_OK))
        else $error("push beat did not complete with ok status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_ctl.count <= lstk_pkg::CNT_W'(lstk_pkg::STACK_DEPTH))
        else $error("record count beyond stack depth");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != lstk_pkg::ST_OK)
        |-> (o_result.rec_key == '0 && o_result.rec_second_key == '0
             && o_result.rec_value == '0 && o_result.rec_tag == '0))
        else $error("failed command returned a nonzero record");

    a_search_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command == lstk_pkg::CMD_SRCH)
        |=> (busy || o_valid))
        else $error("search beat neither scanning nor answered");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for lifo_stack_with_key_search: directed and random command beats,
// each result checked against a behavioral stack predictor. Needs lstk_pkg and the RTL.
module tb;
    import lstk_pkg::*;

    localparam logic [1:0]       CMD_UNUSED   = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX      = 37'd99999999999;
    localparam logic [VAL_W-1:0] VAL_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int               ITEM_TOTAL   = 1750;
    localparam int               CALM_TAIL    = 150;
    localparam int               DRAIN_CYCLES = 80;
    localparam int               STALL_LIMIT  = 5000;

    typedef struct {
        t_in_beat beat;
        bit       wait_drain;
    } t_planned_cmd;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_beat  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_beat o_result;

    t_planned_cmd     cmd_queue[$];
    t_out_beat        awaited_results[$];
    logic [KEY_W-1:0] planned_keys[$];
    t_rec             stack_recs[STACK_DEPTH];
    int               stack_count   = 0;
    int               gap_left      = 0;
    int               quiet_left    = 0;
    int               stall_cycles  = 0;
    int               fail_count    = 0;
    bit               hold_next     = 1'b0;
    bit               mid_hold_done = 1'b0;

    lifo_stack_with_key_search dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_beat predict_stack_result(t_in_beat b);
        t_out_beat r;
        t_rec      hit;
        bit        has_hit;
        int        i;
        r       = '0;
        hit     = '0;
        has_hit = 1'b0;
        case (b.command)
            CMD_PUSH: begin
                if (stack_count >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_recs[stack_count] = '{key: b.entry_key, second_key: b.entry_second_key,
                                                value: b.entry_value, tag: b.entry_tag};
                    hit = stack_recs[stack_count];
                    has_hit = 1'b1;
                    stack_count++;
                end
            end
            CMD_POP: begin
                if (stack_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_count--;
                    hit = stack_recs[stack_count];
                    has_hit = 1'b1;
                end
            end
            CMD_SRCH: begin
                if (stack_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = stack_count - 1; i >= 0 && !has_hit; i--) begin
                        if (stack_recs[i].key == b.entry_key) begin
                            hit = stack_recs[i];
                            has_hit = 1'b1;
                        end
                    end
                    if (!has_hit) r.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        if (has_hit) begin
            r.rec_key        = hit.key;
            r.rec_second_key = hit.second_key;
            r.rec_value      = hit.value;
            r.rec_tag        = hit.tag;
        end
        r.count_now = stack_count[COUNT_NOW_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return KEY_MAX;
            2, 3, 4: return KEY_W'($urandom_range(0, 7));
            default: return KEY_W'(w % 64'd100000000000);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic plan_cmd(logic [1:0] code, logic [KEY_W-1:0] key, logic [KEY_W-1:0] skey,
                            logic [VAL_W-1:0] val, logic [TAG_W-1:0] tag);
        t_planned_cmd p;
        p.beat.command          = t_cmd'(code);
        p.beat.entry_key        = key;
        p.beat.entry_second_key = skey;
        p.beat.entry_value      = val;
        p.beat.entry_tag        = tag;
        p.wait_drain            = hold_next;
        hold_next               = 1'b0;
        cmd_queue.push_back(p);
        if (code == CMD_PUSH && planned_keys.size() < STACK_DEPTH) planned_keys.push_back(key);
        if (code == CMD_POP && planned_keys.size() > 0) void'(planned_keys.pop_back());
    endtask

    task automatic plan_rand(logic [1:0] code);
        logic [KEY_W-1:0] key;
        key = rand_key();
        if (code == CMD_SRCH && planned_keys.size() > 0 && $urandom_range(0, 3) != 0)
            key = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
        plan_cmd(code, key, rand_key(), rand_value(), TAG_W'($urandom_range(0, 255)));
    endtask

    task automatic plan_random_phase();
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                // fill up, then push into and search a full stack
                while (planned_keys.size() < STACK_DEPTH) begin
                    if ($urandom_range(0, 9) == 0) plan_rand(CMD_SRCH);
                    else plan_rand(CMD_PUSH);
                end
                n = $urandom_range(1, 3);
                repeat (n) plan_rand(CMD_PUSH);
                plan_rand(CMD_SRCH);
            end
            2: begin
                while (planned_keys.size() > 0) begin
                    if ($urandom_range(0, 7) == 0) plan_rand(CMD_SRCH);
                    else plan_rand(CMD_POP);
                end
                n = $urandom_range(1, 2);
                repeat (n) plan_rand(CMD_POP);
                plan_rand(CMD_SRCH);
                plan_rand(CMD_UNUSED);
            end
            default: begin
                n = $urandom_range(10, 60);
                repeat (n) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7: plan_rand(CMD_PUSH);
                        8, 9, 10, 11, 12:       plan_rand(CMD_POP);
                        19:                     plan_rand(CMD_UNUSED);
                        default:                plan_rand(CMD_SRCH);
                    endcase
                end
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_planned_cmd nxt;
        if (i_rst_n) begin
            if (start && !busy) begin
                awaited_results.push_back(predict_stack_result(i_item));
                if (quiet_left > 0) begin
                    quiet_left--;
                end else if (cmd_queue.size() > CALM_TAIL) begin
                    case ($urandom_range(0, 29))
                        0, 1, 2, 3, 4: gap_left = $urandom_range(1, 16);
                        5:             quiet_left = $urandom_range(20, 80);
                        default: ;
                    endcase
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             (!cmd_queue[0].wait_drain || awaited_results.size() == 0)) begin
                    nxt = cmd_queue.pop_front();
                    start  <= 1'b1;
                    i_item <= nxt.beat;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, got %h", $time, o_result);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", VAL_W'(want.status), VAL_W'(o_result.status));
                check_field("rec_key", VAL_W'(want.rec_key), VAL_W'(o_result.rec_key));
                check_field("rec_second_key", VAL_W'(want.rec_second_key),
                            VAL_W'(o_result.rec_second_key));
                check_field("rec_value", want.rec_value, o_result.rec_value);
                check_field("rec_tag", VAL_W'(want.rec_tag), VAL_W'(o_result.rec_tag));
                check_field("count_now", VAL_W'(want.count_now), VAL_W'(o_result.count_now));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid === 1'b1) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("** lifo_stack_with_key_search: FAILED **");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        plan_cmd(CMD_POP, KEY_MAX, KEY_MAX, VAL_MAX, 8'hFF);
        plan_cmd(CMD_SRCH, '0, '0, '0, '0);
        plan_cmd(CMD_UNUSED, KEY_MAX, KEY_MAX, VAL_MIN, 8'hFF);
        plan_cmd(CMD_PUSH, '0, '0, '0, '0);
        plan_cmd(CMD_PUSH, KEY_MAX, KEY_MAX, VAL_MIN, 8'hFF);
        plan_cmd(CMD_PUSH, 37'd12345, KEY_MAX, VAL_MAX, 8'h5A);
        plan_cmd(CMD_PUSH, '0, 37'd42, '1, 8'hA5);
        plan_cmd(CMD_SRCH, '0, '0, '0, '0);
        plan_cmd(CMD_SRCH, KEY_MAX, '0, '0, '0);
        plan_cmd(CMD_SRCH, 37'd777, '0, '0, '0);
        plan_cmd(CMD_UNUSED, '0, '0, '0, '0);
        plan_cmd(CMD_POP, '0, '0, '0, '0);
        plan_cmd(CMD_SRCH, '0, KEY_MAX, VAL_MAX, 8'hFF);
        plan_cmd(CMD_POP, '0, '0, '0, '0);
        plan_cmd(CMD_POP, '0, '0, '0, '0);
        plan_cmd(CMD_POP, '0, '0, '0, '0);
        plan_cmd(CMD_POP, '0, '0, '0, '0);
        plan_cmd(CMD_SRCH, KEY_MAX, '0, '0, '0);
        hold_next = 1'b1;
        while (cmd_queue.size() < ITEM_TOTAL) begin
            if (!mid_hold_done && cmd_queue.size() >= ITEM_TOTAL / 2) begin
                hold_next     = 1'b1;
                mid_hold_done = 1'b1;
            end
            plan_random_phase();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (cmd_queue.size() == 0 && !start && awaited_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("** lifo_stack_with_key_search: PASSED **");
        end else begin
            $display("** lifo_stack_with_key_search: FAILED **");
        end
        $finish;
    end

endmodule

[lifo_stack_with_key_search.f]
design/lstk_pkg.sv
design/lstk_ram.sv
design/lstk_ctrl.sv
design/lifo_stack_with_key_search.sv
tb/tb.sv
